### hw/rtl/cpfe_pkg.sv
// ----------------------------------------------------------------------------
// cpfe_pkg
// Shared types, sizes and codes of the clipped pixel fill engine.
// ----------------------------------------------------------------------------
`default_nettype none

package cpfe_pkg;

  localparam int unsigned MAX_WIDTH   = 256;
  localparam int unsigned MAX_HEIGHT  = 256;
  localparam int unsigned STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
  localparam int unsigned COL_W       = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W       = $clog2(MAX_HEIGHT);
  localparam int unsigned DIM_W       = $clog2(((MAX_WIDTH > MAX_HEIGHT) ?
                                                 MAX_WIDTH : MAX_HEIGHT) + 1);

  localparam int unsigned COORD_W = 16;
  localparam int unsigned CALC_W  = COORD_W + 2;
  localparam int unsigned COLOR_W = 32;
  localparam int unsigned TYPE_W  = 3;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = CFG_DATA_W'(256);
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = CFG_DATA_W'(256);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [TYPE_W-1:0] {
    REQ_PLOT  = 3'd0,
    REQ_SPAN  = 3'd1,
    REQ_RECT  = 3'd2,
    REQ_CLEAR = 3'd3,
    REQ_READ  = 3'd4
  } req_type_e;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } cmd_op_e;

  // clipped command as handed from front to back
  typedef struct packed {
    cmd_op_e            op;
    logic [COL_W-1:0]   x0;
    logic [COL_W-1:0]   x1;
    logic [ROW_W-1:0]   y0;
    logic [ROW_W-1:0]   y1;
    logic [DIM_W-1:0]   width;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE  = 3'd0,
    BK_SETUP = 3'd1,
    BK_FILL  = 3'd2,
    BK_READ  = 3'd3,
    BK_DONE  = 3'd4
  } back_state_e;

endpackage

`default_nettype wire

### hw/rtl/cpfe_if.sv
// ----------------------------------------------------------------------------
// cpfe channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpfe_req_if;
  logic                                    valid;
  logic                                    ready;
  logic        [cpfe_pkg::TYPE_W-1:0]      req_type;
  logic signed [cpfe_pkg::COORD_W-1:0]     pos_x;
  logic signed [cpfe_pkg::COORD_W-1:0]     pos_y;
  logic signed [cpfe_pkg::COORD_W-1:0]     span_end_y;
  logic signed [cpfe_pkg::COORD_W-1:0]     extent_w;
  logic signed [cpfe_pkg::COORD_W-1:0]     extent_h;
  logic        [cpfe_pkg::COLOR_W-1:0]     fill_color;

  modport source (output valid, req_type, pos_x, pos_y, span_end_y, extent_w,
                  extent_h, fill_color, input ready);
  modport sink   (input valid, req_type, pos_x, pos_y, span_end_y, extent_w,
                  extent_h, fill_color, output ready);
endinterface

interface cpfe_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [cpfe_pkg::COLOR_W-1:0]     read_color;
  logic                             in_frame;

  modport source (output valid, read_color, in_frame, input ready);
  modport sink   (input valid, read_color, in_frame, output ready);
endinterface

interface cpfe_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [cpfe_pkg::CFG_IDX_W-1:0]      reg_index;
  logic [cpfe_pkg::CFG_DATA_W-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

### hw/rtl/cpfe_ram.sv
// ----------------------------------------------------------------------------
// cpfe_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cpfe_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cpfe_front.sv
// ----------------------------------------------------------------------------
// cpfe_front
// Holds the frame size, takes requests and clips them to a pixel box.
// ----------------------------------------------------------------------------
`default_nettype none

module cpfe_front (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  cpfe_req_if.sink            req,
  cpfe_cfg_if.sink            cfg,
  input  wire logic           q_full_i,
  output logic                push_o,
  output cpfe_pkg::cmd_t      cmd_o
);

  localparam int unsigned CW = cpfe_pkg::CALC_W;

  logic [cpfe_pkg::CFG_DATA_W-1:0] fw_q, fh_q;
  logic [cpfe_pkg::DIM_W-1:0]      w_eff, h_eff;
  logic signed [CW-1:0] px, py, ey, ew, eh, wm1, hm1;
  logic signed [CW-1:0] lo_x, hi_x, lo_y, hi_y, x0, x1, y0, y1;
  logic                 hit;
  cpfe_pkg::cmd_op_e    op;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= cpfe_pkg::FRAME_WIDTH_RST;
      fh_q <= cpfe_pkg::FRAME_HEIGHT_RST;
    end else if (cfg.valid) begin
      if (cfg.reg_index == cpfe_pkg::CFG_FRAME_WIDTH) begin
        fw_q <= cfg.wdata;
      end
      if (cfg.reg_index == cpfe_pkg::CFG_FRAME_HEIGHT) begin
        fh_q <= cfg.wdata;
      end
    end
  end

  // oversized register values saturate to the store size
  always_comb begin
    if (32'(fw_q) > cpfe_pkg::MAX_WIDTH) begin
      w_eff = cpfe_pkg::DIM_W'(cpfe_pkg::MAX_WIDTH);
    end else begin
      w_eff = cpfe_pkg::DIM_W'(fw_q);
    end
    if (32'(fh_q) > cpfe_pkg::MAX_HEIGHT) begin
      h_eff = cpfe_pkg::DIM_W'(cpfe_pkg::MAX_HEIGHT);
    end else begin
      h_eff = cpfe_pkg::DIM_W'(fh_q);
    end
  end

  assign px  = CW'(req.pos_x);
  assign py  = CW'(req.pos_y);
  assign ey  = CW'(req.span_end_y);
  assign ew  = CW'(req.extent_w);
  assign eh  = CW'(req.extent_h);
  assign wm1 = $signed(CW'(w_eff)) - CW'(1);
  assign hm1 = $signed(CW'(h_eff)) - CW'(1);

  // unclipped box; a non-positive extent gives hi < lo and so an empty box
  always_comb begin
    lo_x = px;
    hi_x = px;
    lo_y = py;
    hi_y = py;
    op   = cpfe_pkg::OP_NONE;
    case (req.req_type)
      cpfe_pkg::REQ_PLOT: begin
        op = cpfe_pkg::OP_WRITE;
      end
      cpfe_pkg::REQ_SPAN: begin
        op = cpfe_pkg::OP_WRITE;
        if (py > ey) begin
          lo_y = ey;
          hi_y = py;
        end else begin
          hi_y = ey;
        end
      end
      cpfe_pkg::REQ_RECT: begin
        op   = cpfe_pkg::OP_WRITE;
        hi_x = px + ew - CW'(1);
        hi_y = py + eh - CW'(1);
      end
      cpfe_pkg::REQ_CLEAR: begin
        op   = cpfe_pkg::OP_WRITE;
        lo_x = '0;
        hi_x = wm1;
        lo_y = '0;
        hi_y = hm1;
      end
      cpfe_pkg::REQ_READ: begin
        op = cpfe_pkg::OP_READ;
      end
      default: begin
        op = cpfe_pkg::OP_NONE;
      end
    endcase
  end

  assign x0  = (lo_x < 0) ? '0 : lo_x;
  assign y0  = (lo_y < 0) ? '0 : lo_y;
  assign x1  = (hi_x > wm1) ? wm1 : hi_x;
  assign y1  = (hi_y > hm1) ? hm1 : hi_y;
  assign hit = (x0 <= x1) && (y0 <= y1);

  assign req.ready = !q_full_i;
  assign push_o    = req.valid && !q_full_i;

  always_comb begin
    cmd_o.op    = hit ? op : cpfe_pkg::OP_NONE;
    cmd_o.x0    = x0[cpfe_pkg::COL_W-1:0];
    cmd_o.x1    = x1[cpfe_pkg::COL_W-1:0];
    cmd_o.y0    = y0[cpfe_pkg::ROW_W-1:0];
    cmd_o.y1    = y1[cpfe_pkg::ROW_W-1:0];
    cmd_o.width = w_eff;
    cmd_o.color = req.fill_color;
  end

endmodule

`default_nettype wire

### hw/rtl/cpfe_queue.sv
// ----------------------------------------------------------------------------
// cpfe_queue
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cpfe_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire cpfe_pkg::cmd_t  cmd_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output cpfe_pkg::cmd_t       head_o
);

  cpfe_pkg::cmd_t                slot_q [cpfe_pkg::QUEUE_DEPTH];
  logic [cpfe_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [cpfe_pkg::QCNT_W-1:0]   count_q;
  logic                          do_push, do_pop;

  assign full_o  = (32'(count_q) == cpfe_pkg::QUEUE_DEPTH);
  assign empty_o = (count_q == '0);
  assign head_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (32'(wr_ptr_q) == cpfe_pkg::QUEUE_DEPTH - 1) ? '0
                    : wr_ptr_q + cpfe_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == cpfe_pkg::QUEUE_DEPTH - 1) ? '0
                    : rd_ptr_q + cpfe_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + cpfe_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - cpfe_pkg::QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/cpfe_back.sv
// ----------------------------------------------------------------------------
// cpfe_back
// Walks the clipped box one pixel per cycle, serves reads, issues results.
// ----------------------------------------------------------------------------
`default_nettype none

module cpfe_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            q_empty_i,
  input  wire cpfe_pkg::cmd_t  q_head_i,
  output logic                 pop_o,
  cpfe_rsp_if.source           rsp
);

  cpfe_pkg::back_state_e           state_q, state_d;
  cpfe_pkg::cmd_t                  cmd_q;
  logic [cpfe_pkg::COL_W-1:0]      x_q;
  logic [cpfe_pkg::ROW_W-1:0]      y_q;
  logic [cpfe_pkg::ADDR_W-1:0]     base_q;
  logic                            rsp_valid_q;
  logic [cpfe_pkg::COLOR_W-1:0]    rsp_color_q;
  logic                            rsp_in_frame_q;
  logic                            ram_we, ram_re, load_rsp, row_end, last_px;
  logic [cpfe_pkg::ADDR_W-1:0]     ram_addr;
  logic [cpfe_pkg::COLOR_W-1:0]    ram_rdata;
  logic [cpfe_pkg::ROW_W+cpfe_pkg::DIM_W-1:0] row_prod;

  assign row_end  = (x_q == cmd_q.x1);
  assign last_px  = row_end && (y_q == cmd_q.y1);
  assign ram_addr = base_q + cpfe_pkg::ADDR_W'(x_q);
  assign row_prod = (cpfe_pkg::ROW_W+cpfe_pkg::DIM_W)'(cmd_q.y0) *
                    (cpfe_pkg::ROW_W+cpfe_pkg::DIM_W)'(cmd_q.width);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cpfe_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          state_d = (q_head_i.op == cpfe_pkg::OP_NONE) ? cpfe_pkg::BK_DONE
                                                       : cpfe_pkg::BK_SETUP;
        end
      end
      cpfe_pkg::BK_SETUP: begin
        state_d = (cmd_q.op == cpfe_pkg::OP_READ) ? cpfe_pkg::BK_READ
                                                  : cpfe_pkg::BK_FILL;
      end
      cpfe_pkg::BK_FILL: begin
        if (last_px) begin
          state_d = cpfe_pkg::BK_DONE;
        end
      end
      cpfe_pkg::BK_READ: begin
        state_d = cpfe_pkg::BK_DONE;
      end
      cpfe_pkg::BK_DONE: begin
        if (!rsp_valid_q || rsp.ready) begin
          state_d = cpfe_pkg::BK_IDLE;
        end
      end
      default: begin
        state_d = cpfe_pkg::BK_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    pop_o    = 1'b0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    load_rsp = 1'b0;
    case (state_q)
      cpfe_pkg::BK_IDLE:  pop_o    = !q_empty_i;
      cpfe_pkg::BK_FILL:  ram_we   = 1'b1;
      cpfe_pkg::BK_READ:  ram_re   = 1'b1;
      cpfe_pkg::BK_DONE:  load_rsp = !rsp_valid_q || rsp.ready;
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cpfe_pkg::BK_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_rsp) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_head_i;
    end
    if (state_q == cpfe_pkg::BK_SETUP) begin
      base_q <= row_prod[cpfe_pkg::ADDR_W-1:0];
      x_q    <= cmd_q.x0;
      y_q    <= cmd_q.y0;
    end else if (ram_we) begin
      // walk left to right, then step one row down
      if (row_end) begin
        x_q    <= cmd_q.x0;
        y_q    <= y_q + cpfe_pkg::ROW_W'(1);
        base_q <= base_q + cpfe_pkg::ADDR_W'(cmd_q.width);
      end else begin
        x_q <= x_q + cpfe_pkg::COL_W'(1);
      end
    end
    if (load_rsp) begin
      rsp_in_frame_q <= (cmd_q.op == cpfe_pkg::OP_READ);
      rsp_color_q    <= (cmd_q.op == cpfe_pkg::OP_READ) ? ram_rdata : '0;
    end
  end

  cpfe_ram #(
    .WIDTH (cpfe_pkg::COLOR_W),
    .DEPTH (cpfe_pkg::STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (cmd_q.color),
    .rdata_o (ram_rdata)
  );

  assign rsp.valid      = rsp_valid_q;
  assign rsp.read_color = rsp_color_q;
  assign rsp.in_frame   = rsp_in_frame_q;

endmodule

`default_nettype wire

### hw/rtl/clipped_pixel_fill_engine_top.sv
// ----------------------------------------------------------------------------
// clipped_pixel_fill_engine_top
// Pixel store with clipped plot, span, rectangle, clear and read commands.
//
//   channel  dir  carries
//   req      in   req_type, pos_x, pos_y, span_end_y, extent_w, extent_h,
//                 fill_color
//   rsp      out  read_color, in_frame
//   cfg      in   reg_index (0 frame_width, 1 frame_height), wdata
//
// A command leaves the queue, passes a setup step (row base multiply), then
// writes one clipped pixel per cycle through the single store port and posts
// its result; a read does one store read instead, an empty one goes to posting.
// The two-entry queue keeps taking items while the back end draws or while a
// result waits on rsp. Reset sets the frame to 256 by 256 and leaves the
// store contents undefined; no clearing pass runs.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_pixel_fill_engine_top (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cpfe_req_if.sink   req,
  cpfe_rsp_if.source rsp,
  cpfe_cfg_if.sink   cfg
);

  logic           q_full, q_empty, push, pop;
  cpfe_pkg::cmd_t cmd_in, cmd_head;

  cpfe_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req      (req),
    .cfg      (cfg),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (cmd_in)
  );

  cpfe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .head_o  (cmd_head)
  );

  cpfe_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_head_i  (cmd_head),
    .pop_o     (pop),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
